// File: rtl/gdd_pkg.sv
// Shared constants and the month table for the Gregorian date difference block.
package gdd_pkg;

	localparam int DEF_MAX_YEAR = 9999;
	localparam int YEAR_IN_W    = 14;
	localparam int MONTH_W      = 4;
	localparam int DAY_W        = 5;
	localparam int COUNT_W      = 22;
	localparam int COUNT_MAX    = 4194303;
	localparam int QUEUE_DEPTH  = 2;
	localparam int DAYS_PER_YEAR = 365;
	localparam int CENTURY      = 100;
	localparam int DBM_W        = 9;

	// Reciprocal of one hundred, exact for every year below 2**15.
	localparam int DIV100_MUL   = 5243;
	localparam int DIV100_MUL_W = 13;
	localparam int DIV100_SHIFT = 19;

	localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

	function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
		logic [DBM_W-1:0] r;
		unique case (m)
			4'd1:    r = DBM_W'(0);
			4'd2:    r = DBM_W'(31);
			4'd3:    r = DBM_W'(59);
			4'd4:    r = DBM_W'(90);
			4'd5:    r = DBM_W'(120);
			4'd6:    r = DBM_W'(151);
			4'd7:    r = DBM_W'(181);
			4'd8:    r = DBM_W'(212);
			4'd9:    r = DBM_W'(243);
			4'd10:   r = DBM_W'(273);
			4'd11:   r = DBM_W'(304);
			4'd12:   r = DBM_W'(334);
			default: r = DBM_W'(0);
		endcase
		return r;
	endfunction

endpackage

// File: rtl/gdd_front.sv
// Front end: takes an input word and clamps its year and month fields before queueing.
module gdd_front import gdd_pkg::*; #(
	parameter int MAX_YEAR = DEF_MAX_YEAR,
	localparam int YW = $clog2(MAX_YEAR + 1),
	localparam int IW = 2 * (YW + MONTH_W + DAY_W) + 1
) (
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [YEAR_IN_W-1:0] first_year,
	input  logic [MONTH_W-1:0]   first_month,
	input  logic [DAY_W-1:0]     first_day,
	input  logic [YEAR_IN_W-1:0] second_year,
	input  logic [MONTH_W-1:0]   second_month,
	input  logic [DAY_W-1:0]     second_day,
	input  logic                 include_last_day,
	output logic                 push_valid,
	input  logic                 push_ready,
	output logic [IW-1:0]        push_data
);

	function automatic logic [YW-1:0] clamp_year(input logic [YEAR_IN_W-1:0] y);
		return (32'(y) > 32'(MAX_YEAR)) ? YW'(MAX_YEAR) : YW'(y);
	endfunction

	function automatic logic [MONTH_W-1:0] clamp_month(input logic [MONTH_W-1:0] m);
		logic [MONTH_W-1:0] r;
		priority if (m < MONTH_JAN) begin
			r = MONTH_JAN;
		end else if (m > MONTH_DEC) begin
			r = MONTH_DEC;
		end else begin
			r = m;
		end
		return r;
	endfunction

	assign push_valid = in_valid;
	assign in_ready   = push_ready;
	assign push_data  = {clamp_year(first_year), clamp_month(first_month), first_day,
		clamp_year(second_year), clamp_month(second_month), second_day, include_last_day};

endmodule

// File: rtl/gdd_queue.sv
// Two-word queue that decouples the front end from the day-count engine.
module gdd_queue import gdd_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]  mem [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != CW'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != CW'(0));
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: rtl/gdd_back.sv
// Back end: turns both dates into day ordinals, dividing each year by one hundred by reciprocal.
module gdd_back import gdd_pkg::*; #(
	parameter int MAX_YEAR = DEF_MAX_YEAR,
	localparam int YW = $clog2(MAX_YEAR + 1),
	localparam int IW = 2 * (YW + MONTH_W + DAY_W) + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  logic [IW-1:0]      pop_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COUNT_W-1:0] day_count
);

	localparam int OW   = $clog2(366 * (MAX_YEAR + 1) + 400);
	localparam int RW   = $clog2(CENTURY);
	localparam int PW   = YW + DIV100_MUL_W;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DIV  = 6'b000010,
		ST_REM  = 6'b000100,
		ST_MUL  = 6'b001000,
		ST_ADD  = 6'b010000,
		ST_OUT  = 6'b100000
	} back_state_t;

	back_state_t        state_q;
	logic [IW-1:0]      item_q;
	logic               sel_q;
	logic [YW-1:0]      quo_q;
	logic [RW-1:0]      rem_q;
	logic [OW-1:0]      prod_q;
	logic [OW-1:0]      part_q;
	logic [OW-1:0]      ord_a_q;
	logic               out_valid_q;
	logic [COUNT_W-1:0] day_count_q;

	logic [YW-1:0]      a_y, b_y, y;
	logic [MONTH_W-1:0] a_m, b_m, m;
	logic [DAY_W-1:0]   a_d, b_d, d;
	logic               flag;
	logic [PW-1:0]      recip;
	logic [YW-1:0]      hundreds;
	logic [OW-1:0]      ceil100;
	logic [OW-1:0]      ceil400;
	logic [OW-1:0]      quarter;
	logic               leap;
	logic [OW-1:0]      ord;
	logic [OW-1:0]      diff;
	logic [OW:0]        total;

	assign {a_y, a_m, a_d, b_y, b_m, b_d, flag} = item_q;
	assign y = sel_q ? b_y : a_y;
	assign m = sel_q ? b_m : a_m;
	assign d = sel_q ? b_d : a_d;

	assign recip    = PW'(y) * PW'(DIV100_MUL);
	assign hundreds = quo_q * YW'(CENTURY);

	assign ceil100 = OW'(quo_q) + OW'(rem_q != '0);
	assign ceil400 = (ceil100 + OW'(3)) >> 2;
	assign quarter = (OW'(y) + OW'(3)) >> 2;
	assign leap    = (y[1:0] == 2'b00) && ((rem_q != '0) || (quo_q[1:0] == 2'b00));

	assign ord   = prod_q + part_q;
	assign diff  = (ord_a_q >= ord) ? ord_a_q - ord : ord - ord_a_q;
	assign total = (OW+1)'(diff) + (OW+1)'(flag);

	assign pop_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign day_count = day_count_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				item_q <= pop_data;
			end
			ST_MUL: begin
				prod_q <= OW'(DAYS_PER_YEAR) * OW'(y);
				part_q <= quarter - ceil100 + ceil400 + OW'(days_before_month(m))
					+ OW'((m > MONTH_FEB) && leap) + OW'(d);
			end
			ST_ADD: begin
				if (!sel_q) begin
					ord_a_q <= ord;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= 1'b0;
			quo_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
			day_count_q <= '0;
		end else begin
			if ((state_q == ST_OUT) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						sel_q   <= 1'b0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					quo_q   <= YW'(recip >> DIV100_SHIFT);
					state_q <= ST_REM;
				end
				ST_REM: begin
					rem_q   <= RW'(y - hundreds);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (!sel_q) begin
						sel_q   <= 1'b1;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						day_count_q <= (32'(total) > 32'(COUNT_MAX)) ?
							COUNT_W'(COUNT_MAX) : COUNT_W'(total);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/gregorian_date_difference.sv
// Top level of the Gregorian date difference block.
// Each input word carries two dates and a flag; the block returns the absolute number of days
// between them, plus one when include_last_day is set, saturated to the width of day_count.
// Years above MAX_YEAR are clamped to it, month zero reads as January and months above twelve
// as December, and days are counted from the start of the month without checking. The day-count
// engine takes one word at a time: for each date in turn it divides the year by one hundred by
// reciprocal multiplication, forms the remainder, the year product and the final sum; after both
// dates it loads the result register and returns to idle, where the next word is taken. A two-word
// queue lets new words be taken while the engine is busy, and the result register lets the engine
// start on the next word while a result waits.
module gregorian_date_difference import gdd_pkg::*; #(
	parameter int MAX_YEAR = DEF_MAX_YEAR
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [YEAR_IN_W-1:0] first_year,
	input  logic [MONTH_W-1:0]   first_month,
	input  logic [DAY_W-1:0]     first_day,
	input  logic [YEAR_IN_W-1:0] second_year,
	input  logic [MONTH_W-1:0]   second_month,
	input  logic [DAY_W-1:0]     second_day,
	input  logic                 include_last_day,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [COUNT_W-1:0]   day_count
);

	localparam int YW = $clog2(MAX_YEAR + 1);
	localparam int IW = 2 * (YW + MONTH_W + DAY_W) + 1;

	logic          push_valid;
	logic          push_ready;
	logic [IW-1:0] push_data;
	logic          pop_valid;
	logic          pop_ready;
	logic [IW-1:0] pop_data;

	gdd_front #(.MAX_YEAR(MAX_YEAR)) u_front (
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.first_year       (first_year),
		.first_month      (first_month),
		.first_day        (first_day),
		.second_year      (second_year),
		.second_month     (second_month),
		.second_day       (second_day),
		.include_last_day (include_last_day),
		.push_valid       (push_valid),
		.push_ready       (push_ready),
		.push_data        (push_data)
	);

	gdd_queue #(.W(IW)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	gdd_back #(.MAX_YEAR(MAX_YEAR)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.day_count (day_count)
	);

endmodule

// File: rtl/gdd_checker.sv
// Port-level checker for the Gregorian date difference block, bound to the top level.
module gdd_checker import gdd_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [COUNT_W-1:0]   day_count
);

	localparam int MAX_PENDING = QUEUE_DEPTH + 2;

	logic [3:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 4'd1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 4'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(day_count))
		else $error("A result word changed or vanished while stalled.");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (pending_q != 4'd0) || in_acc)
		else $error("A result word left without a matching input word.");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pending_q) <= MAX_PENDING)
		else $error("More words in flight than the queue and engine can hold.");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pending_q) == MAX_PENDING |-> !in_ready)
		else $error("Input accepted while every holding place was occupied.");

endmodule

bind gregorian_date_difference gdd_checker u_gdd_checker (.*);
